>>> hdl/vbalu_pkg.sv
// ----------------------------------------------------------------------------
// vbalu_pkg
// Types, opcode codes and bit helper functions for the vector bit-manipulation
// element ALU.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package vbalu_pkg;

  localparam int unsigned DataW  = 64;
  localparam int unsigned ModeW  = 4;
  localparam int unsigned EwCodeW = 2;
  localparam int unsigned ShAmtW = 6;

  typedef logic [DataW-1:0] data_t;

  typedef enum logic [ModeW-1:0] {
    MODE_ANDN  = 4'd0,
    MODE_BREV8 = 4'd1,
    MODE_REV8  = 4'd2,
    MODE_ROL   = 4'd3,
    MODE_ROR   = 4'd4,
    MODE_BREV  = 4'd5,
    MODE_CLZ   = 4'd6,
    MODE_CTZ   = 4'd7,
    MODE_CPOP  = 4'd8,
    MODE_WSLL  = 4'd9
  } mode_t;

  typedef enum logic [EwCodeW-1:0] {
    EW_8  = 2'd0,
    EW_16 = 2'd1,
    EW_32 = 2'd2,
    EW_64 = 2'd3
  } ew_t;

  // Full 64-bit bit reverse.
  function automatic data_t rev_bits(input data_t x);
    data_t r;
    for (int i = 0; i < DataW; i++) begin
      r[i] = x[DataW-1-i];
    end
    return r;
  endfunction

  // Reverse bit order inside every byte.
  function automatic data_t rev_bits_in_bytes(input data_t x);
    data_t r;
    for (int k = 0; k < DataW / 8; k++) begin
      for (int i = 0; i < 8; i++) begin
        r[8*k+i] = x[8*k+7-i];
      end
    end
    return r;
  endfunction

  // Full 64-bit byte swap.
  function automatic data_t swap_bytes(input data_t x);
    data_t r;
    for (int k = 0; k < DataW / 8; k++) begin
      r[8*k +: 8] = x[DataW-8-8*k +: 8];
    end
    return r;
  endfunction

  // Leading zero count over 64 bits, 0..64, by halving in six steps.
  function automatic logic [ShAmtW:0] lzc64(input data_t x);
    logic [ShAmtW:0] n;
    data_t v;
    n = '0;
    v = x;
    if (v == '0) begin
      n = (ShAmtW+1)'(DataW);
    end else begin
      if (v[63:32] == '0) begin n = n + 7'd32; v = v << 32; end
      if (v[63:48] == '0) begin n = n + 7'd16; v = v << 16; end
      if (v[63:56] == '0) begin n = n + 7'd8;  v = v << 8;  end
      if (v[63:60] == '0) begin n = n + 7'd4;  v = v << 4;  end
      if (v[63:62] == '0) begin n = n + 7'd2;  v = v << 2;  end
      if (v[63] == 1'b0)  begin n = n + 7'd1; end
    end
    return n;
  endfunction

  // Population count: per-byte sums, then a short add of eight bytes.
  function automatic logic [ShAmtW:0] popcnt64(input data_t x);
    logic [3:0] byte_cnt [DataW/8];
    logic [ShAmtW:0] total;
    total = '0;
    for (int k = 0; k < DataW / 8; k++) begin
      byte_cnt[k] = '0;
      for (int i = 0; i < 8; i++) begin
        byte_cnt[k] = byte_cnt[k] + {3'b000, x[8*k+i]};
      end
    end
    for (int k = 0; k < DataW / 8; k++) begin
      total = total + {3'b000, byte_cnt[k]};
    end
    return total;
  endfunction

endpackage

>>> hdl/vbalu_in_if.sv
// ----------------------------------------------------------------------------
// vbalu_in_if
// Request channel: opcode and two source elements, valid/ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface vbalu_in_if;
  logic        valid;
  logic        ready;
  logic [3:0]  mode;
  logic [63:0] operand_a;
  logic [63:0] operand_b;

  modport source (output valid, output mode, output operand_a, output operand_b,
                  input ready);
  modport sink   (input valid, input mode, input operand_a, input operand_b,
                  output ready);
endinterface

>>> hdl/vbalu_out_if.sv
// ----------------------------------------------------------------------------
// vbalu_out_if
// Result channel: result element and illegal flag, valid/ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface vbalu_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] result;
  logic        illegal;

  modport source (output valid, output result, output illegal, input ready);
  modport sink   (input valid, input result, input illegal, output ready);
endinterface

>>> hdl/vector_bitmanip_element_alu.sv
// ----------------------------------------------------------------------------
// vector_bitmanip_element_alu
// Per-element ALU for vector bit-manipulation ops (andn, brev8, rev8, rol,
// ror, brev, clz, ctz, cpop, wsll).
//
// Usage:
//   in_chan  - request: mode, operand_a (vs2), operand_b (vs1), valid/ready.
//   out_chan - result: zero-extended result and illegal flag, valid/ready.
//   cfg_we/cfg_wdata - element width code (0=8, 1=16, 2=32, 3=64 bits).
//     Write only while no request is in flight.
// Path: a request accepted on in_chan passes the input register, one pass
//   of logic and the result register before it is shown on out_chan.
// Throughput: one request per cycle while out_chan.ready stays high, set by
//   the two-stage register pipeline; every op is a single combinational
//   pass between the registers.
// Reset: synchronous, rst_n low clears both stage valid flags and sets the
//   element width to 8 bits. No clearing pass is needed.
// Stall: when out_chan.ready is low, the result register holds; the input
//   register still takes one more request, then in_chan.ready drops until
//   the result drains.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vector_bitmanip_element_alu (
  input  logic                      clk,
  input  logic                      rst_n,
  vbalu_in_if.sink                  in_chan,
  vbalu_out_if.source               out_chan,
  input  logic                      cfg_we,
  input  logic [vbalu_pkg::EwCodeW-1:0] cfg_wdata
);
  import vbalu_pkg::*;

  // configuration
  ew_t ew_r;

  // stage 1: input register
  logic       s1_valid_r;
  logic [3:0] s1_mode_r;
  data_t      s1_a_r;
  data_t      s1_b_r;

  // stage 2: result register
  logic       s2_valid_r;
  data_t      s2_result_r;
  logic       s2_illegal_r;

  logic  in_fire;
  logic  s2_room;
  logic  s2_load;

  data_t wmask;
  data_t wmask2;
  data_t a_m;
  data_t b_m;
  data_t rep;
  logic [ShAmtW-1:0] rot_amt;
  logic [ShAmtW-1:0] wsl_amt;
  logic [ShAmtW:0]   lz_adj;
  logic [ShAmtW:0]   w_val;
  logic [ShAmtW:0]   lzc_a;
  logic [ShAmtW:0]   tzc_a;
  logic [2*DataW-1:0] rep2;
  data_t rol_v;
  data_t ror_v;
  data_t brev_full;
  data_t rev8_full;
  data_t result_nxt;
  logic  illegal_nxt;

  // ---------------------------------------------------------------------------
  // handshake
  assign s2_room     = !s2_valid_r || out_chan.ready;
  assign s2_load     = s1_valid_r && s2_room;
  assign in_chan.ready = !s1_valid_r || s2_room;
  assign in_fire     = in_chan.valid && in_chan.ready;

  assign out_chan.valid   = s2_valid_r;
  assign out_chan.result  = s2_result_r;
  assign out_chan.illegal = s2_illegal_r;

  // ---------------------------------------------------------------------------
  // width-dependent helpers
  always_comb begin
    unique case (ew_r)
      EW_8: begin
        wmask  = 64'h0000_0000_0000_00FF;
        wmask2 = 64'h0000_0000_0000_FFFF;
        lz_adj = 7'd56;
        w_val  = 7'd8;
        rot_amt = {3'b000, s1_b_r[2:0]};
        wsl_amt = {2'b00, s1_b_r[3:0]};
        rep    = {8{s1_a_r[7:0]}};
      end
      EW_16: begin
        wmask  = 64'h0000_0000_0000_FFFF;
        wmask2 = 64'h0000_0000_FFFF_FFFF;
        lz_adj = 7'd48;
        w_val  = 7'd16;
        rot_amt = {2'b00, s1_b_r[3:0]};
        wsl_amt = {1'b0, s1_b_r[4:0]};
        rep    = {4{s1_a_r[15:0]}};
      end
      EW_32: begin
        wmask  = 64'h0000_0000_FFFF_FFFF;
        wmask2 = 64'hFFFF_FFFF_FFFF_FFFF;
        lz_adj = 7'd32;
        w_val  = 7'd32;
        rot_amt = {1'b0, s1_b_r[4:0]};
        wsl_amt = s1_b_r[5:0];
        rep    = {2{s1_a_r[31:0]}};
      end
      default: begin
        wmask  = 64'hFFFF_FFFF_FFFF_FFFF;
        wmask2 = 64'hFFFF_FFFF_FFFF_FFFF;
        lz_adj = 7'd0;
        w_val  = 7'd64;
        rot_amt = s1_b_r[5:0];
        wsl_amt = s1_b_r[5:0];
        rep    = s1_a_r;
      end
    endcase
  end

  assign a_m = s1_a_r & wmask;
  assign b_m = s1_b_r & wmask;

  // rep repeats the element across 64 bits, so a 64-bit rotate of rep
  // equals a w-bit rotate in its low w bits.
  assign rep2  = {rep, rep};
  assign rol_v = 64'((rep2 << rot_amt) >> DataW);
  assign ror_v = 64'(rep2 >> rot_amt);

  assign brev_full = rev_bits(a_m);
  assign rev8_full = swap_bytes(a_m);
  assign lzc_a     = lzc64(a_m);
  assign tzc_a     = lzc64(brev_full);

  // ---------------------------------------------------------------------------
  // element op
  always_comb begin
    result_nxt  = '0;
    illegal_nxt = 1'b0;
    unique case (s1_mode_r)
      MODE_ANDN:  result_nxt = a_m & ~b_m;
      MODE_BREV8: result_nxt = rev_bits_in_bytes(a_m) & wmask;
      MODE_REV8:  result_nxt = rev8_full >> lz_adj;
      MODE_ROL:   result_nxt = rol_v & wmask;
      MODE_ROR:   result_nxt = ror_v & wmask;
      MODE_BREV:  result_nxt = brev_full >> lz_adj;
      MODE_CLZ:   result_nxt = {57'd0, 7'(lzc_a - lz_adj)};
      // zero element: ctz over 64 bits gives 64, clip to element width
      MODE_CTZ:   result_nxt = {57'd0, (tzc_a > w_val) ? w_val : tzc_a};
      MODE_CPOP:  result_nxt = {57'd0, popcnt64(a_m)};
      MODE_WSLL: begin
        if (ew_r == EW_64) begin
          illegal_nxt = 1'b1;
        end else begin
          result_nxt = (a_m << wsl_amt) & wmask2;
        end
      end
      default:    illegal_nxt = 1'b1;
    endcase
  end

  // ---------------------------------------------------------------------------
  // registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ew_r       <= EW_8;
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        ew_r <= ew_t'(cfg_wdata);
      end
      if (in_fire) begin
        s1_valid_r <= 1'b1;
      end else if (s2_room) begin
        s1_valid_r <= 1'b0;
      end
      if (s2_load) begin
        s2_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        s2_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_mode_r <= in_chan.mode;
      s1_a_r    <= in_chan.operand_a;
      s1_b_r    <= in_chan.operand_b;
    end
    if (s2_load) begin
      s2_result_r  <= result_nxt;
      s2_illegal_r <= illegal_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // assertions
  a_illegal_zero: assert property (@(posedge clk) disable iff (!rst_n)
    s2_valid_r && s2_illegal_r |-> s2_result_r == '0)
    else $error("illegal request with nonzero result");

  a_ready_when_room: assert property (@(posedge clk) disable iff (!rst_n)
    (!s1_valid_r || !s2_valid_r || out_chan.ready) |-> in_chan.ready)
    else $error("input stalled while pipeline can advance");

  a_s1_to_s2: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && s2_room |=> s2_valid_r)
    else $error("stage 1 request lost on advance");

  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s2_room |=> s1_valid_r && $stable(s1_a_r))
    else $error("stage 1 request dropped under stall");

  a_byte_width: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && ew_r == EW_8 && s1_mode_r != MODE_WSLL |-> result_nxt[63:8] == '0)
    else $error("8-bit result not zero-extended");

endmodule
